// ----- hdl/trps_pkg.sv -----
// ----------------------------------------------------------------------------
// trps_pkg
// Shared types and constants for the triac phase ramp sequencer.
// ----------------------------------------------------------------------------
package trps_pkg;

    // Default width of the tick counter
    localparam int TICK_COUNT_BITS_DEF = 16;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_PULSES     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DELAY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_PULSES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_STOP_DELAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_STOP_PULSES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_WIDTH       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP       = 3'd7;

    // Configuration reset values
    localparam logic [15:0] RST_START_DELAY      = 16'd151;
    localparam logic [7:0]  RST_START_PULSES     = 8'd10;
    localparam logic [15:0] RST_STOP_DELAY       = 16'd151;
    localparam logic [7:0]  RST_STOP_PULSES      = 8'd6;
    localparam logic [15:0] RST_FAST_STOP_DELAY  = 16'd110;
    localparam logic [7:0]  RST_FAST_STOP_PULSES = 8'd5;
    localparam logic [15:0] RST_FIRE_WIDTH       = 16'd9;
    localparam logic [7:0]  RST_DELAY_STEP       = 8'd0;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;
    localparam logic [1:0] REQ_FAST  = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic       zero_cross;
        logic       left_enable;
        logic       right_enable;
        logic       yarn_break;
        logic       stop_key;
    } trps_in_t;

    typedef struct packed {
        logic triac_left;
        logic triac_right;
        logic busy_res;
        logic ramp_done;
        logic emergency;
    } trps_out_t;

    typedef struct packed {
        logic [15:0] start_delay;
        logic [7:0]  start_pulses;
        logic [15:0] stop_delay;
        logic [7:0]  stop_pulses;
        logic [15:0] fast_stop_delay;
        logic [7:0]  fast_stop_pulses;
        logic [15:0] fire_width;
        logic [7:0]  delay_step;
    } trps_cfg_t;

endpackage

// ----- hdl/triac_phase_ramp_sequencer.sv -----
// ----------------------------------------------------------------------------
// triac_phase_ramp_sequencer
// Phase-angle soft start / soft stop sequencer for two triac gates.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one timing tick and yields exactly one
// result on the m_ channel. The block takes one request per clock cycle and
// keeps that rate as long as m_ready is high. A result shows on m_valid once
// its request has waited in the input register and one pass of the ramp
// next-state logic has loaded the result register. The single pass of that
// next-state logic over the ramp state sets the rate: each tick sees the
// state left by the tick before it.
// When m_ready drops, the result register and the input register each hold
// one request before s_ready falls. Configuration registers are written
// through cfg_wr_en, cfg_index and cfg_wr_data with no wait; write them only
// while no request is in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module triac_phase_ramp_sequencer #(
    parameter int TICK_COUNT_BITS = trps_pkg::TICK_COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  trps_pkg::trps_in_t                s_data,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output trps_pkg::trps_out_t               m_data,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [trps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trps_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import trps_pkg::*;

    logic      in_valid_reg, in_valid_next;
    trps_in_t  in_data_reg;
    logic      slot_free;
    logic      step;
    logic      s_accept;
    trps_cfg_t cfg;
    trps_out_t res;

    // advance one tick whenever a request is held and the result slot opens
    assign step     = in_valid_reg && slot_free;
    assign s_ready  = !in_valid_reg || slot_free;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // hold the request payload until its tick is processed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
    end

    trps_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    trps_ramp_core #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_ramp_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .cfg     (cfg),
        .res     (res)
    );

    trps_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step),
        .res_in    (res),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- hdl/trps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// trps_cfg_regs
// Ramp configuration registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module trps_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [trps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trps_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output trps_pkg::trps_cfg_t               cfg
);
    import trps_pkg::*;

    trps_cfg_t cfg_reg;
    trps_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_DELAY:      cfg_next.start_delay      = cfg_wr_data[15:0];
                REG_START_PULSES:     cfg_next.start_pulses     = cfg_wr_data[7:0];
                REG_STOP_DELAY:       cfg_next.stop_delay       = cfg_wr_data[15:0];
                REG_STOP_PULSES:      cfg_next.stop_pulses      = cfg_wr_data[7:0];
                REG_FAST_STOP_DELAY:  cfg_next.fast_stop_delay  = cfg_wr_data[15:0];
                REG_FAST_STOP_PULSES: cfg_next.fast_stop_pulses = cfg_wr_data[7:0];
                REG_FIRE_WIDTH:       cfg_next.fire_width       = cfg_wr_data[15:0];
                REG_DELAY_STEP:       cfg_next.delay_step       = cfg_wr_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_delay      <= RST_START_DELAY;
            cfg_reg.start_pulses     <= RST_START_PULSES;
            cfg_reg.stop_delay       <= RST_STOP_DELAY;
            cfg_reg.stop_pulses      <= RST_STOP_PULSES;
            cfg_reg.fast_stop_delay  <= RST_FAST_STOP_DELAY;
            cfg_reg.fast_stop_pulses <= RST_FAST_STOP_PULSES;
            cfg_reg.fire_width       <= RST_FIRE_WIDTH;
            cfg_reg.delay_step       <= RST_DELAY_STEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/trps_ramp_core.sv -----
// ----------------------------------------------------------------------------
// trps_ramp_core
// Ramp state and its one-tick next-state logic; produces one result per step.
// ----------------------------------------------------------------------------
module trps_ramp_core #(
    parameter int TICK_COUNT_BITS = trps_pkg::TICK_COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  trps_pkg::trps_in_t   item,
    input  trps_pkg::trps_cfg_t  cfg,
    output trps_pkg::trps_out_t  res
);
    import trps_pkg::*;

    localparam int CMP_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
    localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_SYNC      = 7'b0000010,
        PH_DELAY     = 7'b0000100,
        PH_FIRE      = 7'b0001000,
        PH_WAIT_LOW  = 7'b0010000,
        PH_WAIT_HIGH = 7'b0100000,
        PH_WAIT_END  = 7'b1000000
    } phase_t;

    phase_t                       phase_reg,       phase_next;
    logic [15:0]                  cur_delay_reg,   cur_delay_next;
    logic [TICK_COUNT_BITS-1:0]   tick_cnt_reg,    tick_cnt_next;
    logic [7:0]                   cycles_done_reg, cycles_done_next;
    logic [7:0]                   cycles_tgt_reg,  cycles_tgt_next;
    logic                         last_level_reg,  last_level_next;
    logic                         half_cycle_reg,  half_cycle_next;
    logic                         emergency_reg,   emergency_next;
    logic                         gate_left, gate_right, done;
    logic                         underflow;
    logic                         is_idle;

    function automatic logic limit_hit(input logic [TICK_COUNT_BITS-1:0] tc,
                                       input logic [15:0] lim);
        return (CMP_W'(tc) >= CMP_W'(lim)) || (tc == TICK_MAX);
    endfunction

    assign is_idle = (phase_reg == PH_IDLE);

    always_comb begin
        phase_next       = phase_reg;
        cur_delay_next   = cur_delay_reg;
        tick_cnt_next    = tick_cnt_reg;
        cycles_done_next = cycles_done_reg;
        cycles_tgt_next  = cycles_tgt_reg;
        half_cycle_next  = half_cycle_reg;
        emergency_next   = emergency_reg;
        last_level_next  = item.zero_cross;
        gate_left        = 1'b0;
        gate_right       = 1'b0;
        done             = 1'b0;
        underflow        = (16'(cfg.delay_step) > cur_delay_reg);

        if ((item.req_type == REQ_FAST)
            || (item.req_type == REQ_START && is_idle)
            || (item.req_type == REQ_STOP && is_idle)) begin
            // load a new ramp; apart from the zero-cross level sample, nothing else moves this tick
            phase_next       = PH_SYNC;
            tick_cnt_next    = '0;
            cycles_done_next = 8'd0;
            half_cycle_next  = 1'b0;
            if (item.req_type == REQ_FAST) begin
                emergency_next  = 1'b1;
                cur_delay_next  = cfg.fast_stop_delay;
                cycles_tgt_next = cfg.fast_stop_pulses;
            end else if (item.req_type == REQ_START) begin
                cur_delay_next  = cfg.start_delay;
                cycles_tgt_next = cfg.start_pulses;
            end else begin
                cur_delay_next  = cfg.stop_delay;
                cycles_tgt_next = cfg.stop_pulses;
            end
        end else begin
            // wait phases
            if (phase_next == PH_SYNC && item.zero_cross != last_level_reg) begin
                phase_next    = PH_DELAY;
                tick_cnt_next = '0;
            end else if (phase_next == PH_WAIT_LOW && !item.zero_cross) begin
                phase_next    = PH_DELAY;
                tick_cnt_next = '0;
            end else if (phase_next == PH_WAIT_END && item.zero_cross) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
            end else if (phase_next == PH_WAIT_HIGH && item.zero_cross) begin
                phase_next    = PH_DELAY;
                tick_cnt_next = '0;
            end

            // firing delay
            if (phase_next == PH_DELAY) begin
                if (limit_hit(tick_cnt_next, cur_delay_reg)) begin
                    phase_next    = PH_FIRE;
                    tick_cnt_next = '0;
                end else begin
                    tick_cnt_next = tick_cnt_next + TICK_COUNT_BITS'(1);
                end
            end

            // gate pulse
            if (phase_next == PH_FIRE) begin
                if (!limit_hit(tick_cnt_next, cfg.fire_width)) begin
                    gate_left     = item.left_enable;
                    gate_right    = item.right_enable;
                    tick_cnt_next = tick_cnt_next + TICK_COUNT_BITS'(1);
                end
                if (limit_hit(tick_cnt_next, cfg.fire_width)) begin
                    if (!half_cycle_reg) begin
                        if (item.yarn_break || item.stop_key) begin
                            emergency_next = 1'b1;
                        end
                        half_cycle_next = 1'b1;
                        phase_next      = PH_WAIT_LOW;
                    end else begin
                        half_cycle_next  = 1'b0;
                        cycles_done_next = cycles_done_reg + 8'd1;
                        cur_delay_next   = underflow ? 16'd0
                                         : cur_delay_reg - 16'(cfg.delay_step);
                        phase_next = (underflow || cycles_done_next >= cycles_tgt_reg)
                                   ? PH_WAIT_END : PH_WAIT_HIGH;
                    end
                end
            end
        end

        res.triac_left  = gate_left;
        res.triac_right = gate_right;
        res.busy_res    = (phase_next != PH_IDLE);
        res.ramp_done   = done;
        res.emergency   = emergency_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            cur_delay_reg   <= 16'd0;
            tick_cnt_reg    <= '0;
            cycles_done_reg <= 8'd0;
            cycles_tgt_reg  <= 8'd0;
            last_level_reg  <= 1'b0;
            half_cycle_reg  <= 1'b0;
            emergency_reg   <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            cur_delay_reg   <= cur_delay_next;
            tick_cnt_reg    <= tick_cnt_next;
            cycles_done_reg <= cycles_done_next;
            cycles_tgt_reg  <= cycles_tgt_next;
            last_level_reg  <= last_level_next;
            half_cycle_reg  <= half_cycle_next;
            emergency_reg   <= emergency_next;
        end
    end

`ifndef ASSERT_OFF
    a_emergency_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        emergency_reg |=> emergency_reg)
        else $error("emergency flag cleared without reset");

    a_fast_stop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.req_type == REQ_FAST) |=> (phase_reg == PH_SYNC && emergency_reg))
        else $error("fast stop did not restart the ramp");

    a_idle_first_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> !half_cycle_reg)
        else $error("idle with a half cycle pending");

    a_done_from_wait_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.ramp_done) |-> (phase_reg == PH_WAIT_END))
        else $error("ramp done outside the final wait");

    a_gate_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (res.triac_left || res.triac_right)) |->
            ((res.triac_left == 1'b0 || item.left_enable)
             && (res.triac_right == 1'b0 || item.right_enable)))
        else $error("gate driven without its enable");
`endif

endmodule

// ----- hdl/trps_out_reg.sv -----
// ----------------------------------------------------------------------------
// trps_out_reg
// Result register of the m_ channel; frees its slot in the cycle it drains.
// ----------------------------------------------------------------------------
module trps_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  trps_pkg::trps_out_t  res_in,
    output logic                 slot_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output trps_pkg::trps_out_t  m_data
);
    import trps_pkg::*;

    logic      out_valid_reg, out_valid_next;
    trps_out_t out_data_reg;

    assign slot_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= res_in;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
